>>> sv/adc_pkg.sv
// ----------------------------------------------------------------------------
// Automatic door controller package
// Shared transaction types, register indexes, reset values and output codes.
// ----------------------------------------------------------------------------
package adc_pkg;

	typedef struct packed {
		logic        button_pressed;
		logic [19:0] echo_us;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  door_state_out;
		logic        emergency_out;
		logic [7:0]  motor_duty;
		logic        red_led;
		logic        green_led;
		logic [14:0] distance_cm;
	} out_item_t;

	typedef struct packed {
		logic [15:0] open_distance_cm;
		logic [15:0] travel_time_ms;
		logic [7:0]  run_duty;
	} cfg_t;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_OPEN_DISTANCE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TRAVEL_TIME   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RUN_DUTY      = 2'd2;

	localparam logic [15:0] OPEN_DISTANCE_RST = 16'd100;
	localparam logic [15:0] TRAVEL_TIME_RST   = 16'd2000;
	localparam logic [7:0]  RUN_DUTY_RST      = 8'd200;

	localparam logic [1:0] DOOR_CODE_CLOSED  = 2'd0;
	localparam logic [1:0] DOOR_CODE_OPENING = 2'd1;
	localparam logic [1:0] DOOR_CODE_OPEN    = 2'd2;
	localparam logic [1:0] DOOR_CODE_CLOSING = 2'd3;

	// Ten times the reciprocal of 291 scaled by 2^32, rounded up; exact for all
	// 19-bit half echo widths.
	localparam logic [27:0] DIST_MULT  = 28'd147593378;
	localparam int unsigned DIST_SHIFT = 32;

endpackage

>>> sv/automatic_door_controller.sv
// ----------------------------------------------------------------------------
// Automatic door controller
// Emergency toggle, echo distance and timed four-state door control.
// ----------------------------------------------------------------------------
// Each input transaction on in_valid/in_ready is one control tick carrying the
// button level, the echo width and the millisecond time. Each tick gives
// exactly one result transaction on out_valid/out_ready, in order.
// A tick is captured in an input register, and the door logic and distance
// conversion run between that register and the result register, from which
// the result is offered. One tick per cycle is sustained while the receiver
// takes results; the single 19 by 28 bit constant multiplication of the distance
// conversion sets the critical path.
// When the receiver stalls, the result register holds and the input register
// still takes one more tick; ready falls only once both are full.
// Reset empties both registers, returns the door to closed with emergency mode
// off, and loads the register defaults. Configuration writes through
// cfg_wr_en, cfg_index and cfg_wdata take effect at once; an index past the
// last register is ignored.
// ----------------------------------------------------------------------------
module automatic_door_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  adc_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output adc_pkg::out_item_t                out_data,
	input  logic                              cfg_wr_en,
	input  logic [adc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [adc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import adc_pkg::*;

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;
	logic      load_s2;
	logic [14:0] dist_cm;
	out_item_t result;

	assign load_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || load_s2;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_distance_cm <= OPEN_DISTANCE_RST;
			cfg_q.travel_time_ms   <= TRAVEL_TIME_RST;
			cfg_q.run_duty         <= RUN_DUTY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_OPEN_DISTANCE: cfg_q.open_distance_cm <= cfg_wdata;
				REG_TRAVEL_TIME:   cfg_q.travel_time_ms   <= cfg_wdata;
				REG_RUN_DUTY:      cfg_q.run_duty         <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (load_s2) begin
			res_s2 <= result;
		end
	end

	adc_dist u_dist (
		.echo_us     (item_s1.echo_us),
		.distance_cm (dist_cm)
	);

	adc_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (load_s2),
		.item    (item_s1),
		.dist_cm (dist_cm),
		.cfg     (cfg_q),
		.result  (result)
	);

	a_emergency_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.emergency_out |->
			out_data.motor_duty == 8'd0 && out_data.red_led &&
			out_data.door_state_out == DOOR_CODE_CLOSED && out_data.distance_cm == 15'd0)
		else $error("Emergency result does not show a stopped, closed door.");

	a_motor_only_moving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.motor_duty != 8'd0 |->
			out_data.door_state_out == DOOR_CODE_OPENING ||
			out_data.door_state_out == DOOR_CODE_CLOSING)
		else $error("Motor runs while the door is not moving.");

	a_lamps_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.red_led != out_data.green_led)
		else $error("Red and green lamps agree.");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s2 |=> valid_s1 && $stable(item_s1))
		else $error("Input register lost a transaction while stalled.");

endmodule

>>> sv/adc_dist.sv
// ----------------------------------------------------------------------------
// Echo to distance conversion
// Computes floor(10 * floor(echo / 2) / 291) with one constant multiplication.
// ----------------------------------------------------------------------------
module adc_dist (
	input  logic [19:0] echo_us,
	output logic [14:0] distance_cm
);
	import adc_pkg::*;

	logic [18:0] half;
	logic [46:0] prod;

	assign half        = echo_us[19:1];
	assign prod        = 47'(half) * 47'(DIST_MULT);
	assign distance_cm = prod[DIST_SHIFT+14:DIST_SHIFT];

endmodule

>>> sv/adc_fsm.sv
// ----------------------------------------------------------------------------
// Door state machine
// Holds the door, travel timer and emergency state and forms one result per
// transaction that passes from the input register to the result register.
// ----------------------------------------------------------------------------
module adc_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  adc_pkg::in_item_t item,
	input  logic [14:0]       dist_cm,
	input  adc_pkg::cfg_t     cfg,
	output adc_pkg::out_item_t result
);
	import adc_pkg::*;

	typedef enum logic [3:0] {
		DOOR_CLOSED  = 4'b0001,
		DOOR_OPENING = 4'b0010,
		DOOR_OPEN    = 4'b0100,
		DOOR_CLOSING = 4'b1000
	} door_state_t;

	door_state_t door_q, door_d;
	logic [31:0] travel_start_q, travel_start_d;
	logic        last_button_q;
	logic        emergency_q, emergency_d;

	logic [31:0] elapsed;
	logic        travel_done;
	logic        near;
	logic [7:0]  motor;
	logic        red, green;

	assign emergency_d = emergency_q ^ (item.button_pressed & ~last_button_q);
	assign elapsed     = item.now_ms - travel_start_q;
	assign travel_done = elapsed >= {16'd0, cfg.travel_time_ms};
	assign near        = {1'b0, dist_cm} < cfg.open_distance_cm;

	always_comb begin
		door_d         = door_q;
		travel_start_d = travel_start_q;
		motor          = '0;
		red            = 1'b1;
		green          = 1'b0;
		if (emergency_d) begin
			door_d = DOOR_CLOSED;
		end else begin
			unique case (door_q)
				DOOR_CLOSED: begin
					if (near) begin
						door_d         = DOOR_OPENING;
						travel_start_d = item.now_ms;
					end
				end
				DOOR_OPENING: begin
					red   = 1'b0;
					green = 1'b1;
					motor = cfg.run_duty;
					if (travel_done) begin
						motor  = '0;
						door_d = DOOR_OPEN;
					end
				end
				DOOR_OPEN: begin
					red   = 1'b0;
					green = 1'b1;
					if (!near) begin
						door_d         = DOOR_CLOSING;
						travel_start_d = item.now_ms;
					end
				end
				DOOR_CLOSING: begin
					motor = cfg.run_duty;
					if (travel_done) begin
						motor  = '0;
						door_d = DOOR_CLOSED;
					end
				end
				default: begin
					door_d = DOOR_CLOSED;
				end
			endcase
		end
	end

	always_comb begin
		unique case (door_d)
			DOOR_OPENING: result.door_state_out = DOOR_CODE_OPENING;
			DOOR_OPEN:    result.door_state_out = DOOR_CODE_OPEN;
			DOOR_CLOSING: result.door_state_out = DOOR_CODE_CLOSING;
			default:      result.door_state_out = DOOR_CODE_CLOSED;
		endcase
		result.emergency_out = emergency_d;
		result.motor_duty    = motor;
		result.red_led       = red;
		result.green_led     = green;
		result.distance_cm   = emergency_d ? 15'd0 : dist_cm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_q         <= DOOR_CLOSED;
			travel_start_q <= '0;
			last_button_q  <= 1'b0;
			emergency_q    <= 1'b0;
		end else if (step) begin
			door_q         <= door_d;
			travel_start_q <= travel_start_d;
			last_button_q  <= item.button_pressed;
			emergency_q    <= emergency_d;
		end
	end

endmodule

>>> dv/tb_automatic_door_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Automatic door controller testbench
// Drives control ticks on the input channel and checks every result
// transaction against the directed table's expected values where given, else
// an in-bench model of the emergency toggle, the echo to distance conversion
// and the timed door state machine. A short table of directed ticks runs on
// the reset settings. Random ticks follow under several register settings,
// including the extremes. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_automatic_door_controller;
	import adc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned ECHO_MAX    = 1000000;
	localparam int unsigned DIST_MAX    = 17182;
	localparam int unsigned CM_NUM      = 10;
	localparam int unsigned CM_DEN      = 291;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	typedef enum {RX_FREE, RX_COIN, RX_SLOW, RX_STARVE} rx_mode_t;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	in_item_t               in_data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_data;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	cfg_t        cfg_shadow;
	logic [1:0]  door_now = DOOR_CODE_CLOSED;
	logic [31:0] travel_t0 = '0;
	logic        btn_prev = 1'b0;
	logic        emerg_on = 1'b0;

	out_item_t   pending_results[$];
	plan_row_t   plan_q[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int          burst_left = 0;
	logic        rnd_btn = 1'b0;
	logic [31:0] rnd_time = '0;
	rx_mode_t    rx_mode = RX_FREE;
	int          rx_left = 0;

	automatic_door_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] seen,
			input logic [31:0] want);
		if (seen !== want)
			report_mismatch($sformatf("%s: got %0d, expected %0d", name, seen, want));
	endtask

	function automatic out_item_t door_predict(input in_item_t it);
		out_item_t   r;
		logic [31:0] dist_cm;
		logic [31:0] elapsed;
		r = '0;
		if (it.button_pressed && !btn_prev)
			emerg_on = ~emerg_on;
		btn_prev = it.button_pressed;
		dist_cm = ((32'(it.echo_us) >> 1) * CM_NUM) / CM_DEN;
		elapsed = it.now_ms - travel_t0;
		if (emerg_on) begin
			door_now = DOOR_CODE_CLOSED;
			r.red_led = 1'b1;
		end else begin
			r.distance_cm = dist_cm[14:0];
			case (door_now)
				DOOR_CODE_CLOSED: begin
					r.red_led = 1'b1;
					if (dist_cm < 32'(cfg_shadow.open_distance_cm)) begin
						door_now = DOOR_CODE_OPENING;
						travel_t0 = it.now_ms;
					end
				end
				DOOR_CODE_OPENING: begin
					r.green_led = 1'b1;
					r.motor_duty = cfg_shadow.run_duty;
					if (elapsed >= 32'(cfg_shadow.travel_time_ms)) begin
						r.motor_duty = '0;
						door_now = DOOR_CODE_OPEN;
					end
				end
				DOOR_CODE_OPEN: begin
					r.green_led = 1'b1;
					if (dist_cm >= 32'(cfg_shadow.open_distance_cm)) begin
						door_now = DOOR_CODE_CLOSING;
						travel_t0 = it.now_ms;
					end
				end
				default: begin
					r.red_led = 1'b1;
					r.motor_duty = cfg_shadow.run_duty;
					if (elapsed >= 32'(cfg_shadow.travel_time_ms)) begin
						r.motor_duty = '0;
						door_now = DOOR_CODE_CLOSED;
					end
				end
			endcase
		end
		r.door_state_out = door_now;
		r.emergency_out = emerg_on;
		return r;
	endfunction

	// Random tick: time mostly advances in steps that let travel phases finish,
	// and echoes cluster around the current opening distance.
	function automatic in_item_t next_tick();
		in_item_t    it;
		int unsigned pick;
		int          d;
		int unsigned echo;
		if (rnd_btn)
			rnd_btn = ($urandom_range(99, 0) < 70);
		else
			rnd_btn = ($urandom_range(999, 0) < (emerg_on ? 150 : 15));
		pick = $urandom_range(99, 0);
		if (pick < 80)
			rnd_time += $urandom_range(cfg_shadow.travel_time_ms / 4 + 1, 0);
		else if (pick < 90)
			rnd_time += $urandom_range(3, 0);
		else if (pick < 95)
			rnd_time = $urandom();
		else
			rnd_time -= $urandom_range(500, 1);
		pick = $urandom_range(99, 0);
		if (pick < 50) begin
			d = int'(cfg_shadow.open_distance_cm) + int'($urandom_range(40, 0)) - 20;
			if (d < 0)
				d = 0;
			if (d > int'(DIST_MAX))
				d = DIST_MAX;
			echo = (d * 582) / 10 + $urandom_range(58, 0);
			if (echo > ECHO_MAX)
				echo = ECHO_MAX;
		end else if (pick < 85) begin
			echo = $urandom_range(ECHO_MAX, 0);
		end else if (pick < 92) begin
			echo = 0;
		end else begin
			echo = ECHO_MAX;
		end
		it.button_pressed = rnd_btn;
		it.echo_us = echo[19:0];
		it.now_ms = rnd_time;
		return it;
	endfunction

	task automatic plan_row(input logic btn, input logic [19:0] echo, input logic [31:0] now,
			input bit typed, input logic [1:0] door, input logic emerg,
			input logic [7:0] motor, input logic red, input logic green,
			input logic [14:0] dist_cm);
		plan_row_t row;
		row.stim = '{button_pressed: btn, echo_us: echo, now_ms: now};
		row.typed = typed;
		row.want = '{door_state_out: door, emergency_out: emerg, motor_duty: motor,
			red_led: red, green_led: green, distance_cm: dist_cm};
		plan_q.push_back(row);
	endtask

	task automatic sender_pause();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic push_tick(input in_item_t it, input bit typed, input out_item_t want);
		out_item_t model;
		sender_pause();
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		model = door_predict(it);
		pending_results.push_back(typed ? want : model);
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] word);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= word;
		@(posedge clk);
		case (idx)
			REG_OPEN_DISTANCE: cfg_shadow.open_distance_cm = word;
			REG_TRAVEL_TIME:   cfg_shadow.travel_time_ms = word;
			REG_RUN_DUTY:      cfg_shadow.run_duty = word[7:0];
			default: ;
		endcase
	endtask

	task automatic run_phase(input int n, input logic [15:0] dist_set,
			input logic [15:0] travel_set, input logic [15:0] duty_word);
		write_reg(REG_OPEN_DISTANCE, dist_set);
		write_reg(REG_TRAVEL_TIME, travel_set);
		write_reg(REG_RUN_DUTY, duty_word);
		write_reg(REG_SPARE, 16'($urandom()));
		@(negedge clk) cfg_wr_en <= 1'b0;
		repeat (n)
			push_tick(next_tick(), 1'b0, '0);
		drain();
	endtask

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(3, 0));
			rx_left = $urandom_range(200, 20);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_FREE:  out_ready <= 1'b1;
			RX_COIN:  out_ready <= 1'($urandom_range(1, 0));
			RX_SLOW:  out_ready <= (rx_left % 4 == 0);
			default:  out_ready <= ($urandom_range(15, 0) == 0);
		endcase
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transaction with no tick outstanding");
			end else begin
				want = pending_results.pop_front();
				check_field("door_state_out", 32'(out_data.door_state_out),
					32'(want.door_state_out));
				check_field("emergency_out", 32'(out_data.emergency_out),
					32'(want.emergency_out));
				check_field("motor_duty", 32'(out_data.motor_duty), 32'(want.motor_duty));
				check_field("red_led", 32'(out_data.red_led), 32'(want.red_led));
				check_field("green_led", 32'(out_data.green_led), 32'(want.green_led));
				check_field("distance_cm", 32'(out_data.distance_cm),
					32'(want.distance_cm));
			end
		end
	end

	initial begin
		cfg_shadow.open_distance_cm = OPEN_DISTANCE_RST;
		cfg_shadow.travel_time_ms = TRAVEL_TIME_RST;
		cfg_shadow.run_duty = RUN_DUTY_RST;

		// Reset settings: opening distance 100, travel 2000, duty 200.
		plan_row(0, 0, 0, 1, DOOR_CODE_OPENING, 0, 0, 1, 0, 0);
		plan_row(0, 20'(ECHO_MAX), 1, 1, DOOR_CODE_OPENING, 0, 200, 0, 1, 15'(DIST_MAX));
		plan_row(0, 20'(ECHO_MAX), 2000, 1, DOOR_CODE_OPEN, 0, 0, 0, 1, 15'(DIST_MAX));
		plan_row(0, 20'(ECHO_MAX), 2001, 1, DOOR_CODE_CLOSING, 0, 0, 0, 1, 15'(DIST_MAX));
		plan_row(0, 20'(ECHO_MAX), 2002, 1, DOOR_CODE_CLOSING, 0, 200, 1, 0, 15'(DIST_MAX));
		plan_row(1, 20'(ECHO_MAX), 2003, 1, DOOR_CODE_CLOSED, 1, 0, 1, 0, 0);
		plan_row(1, 0, 2004, 1, DOOR_CODE_CLOSED, 1, 0, 1, 0, 0);
		plan_row(0, 0, 2005, 1, DOOR_CODE_CLOSED, 1, 0, 1, 0, 0);
		plan_row(1, 5820, 2006, 1, DOOR_CODE_CLOSED, 0, 0, 1, 0, 100);
		plan_row(0, 5818, 32'hFFFF_FFF0, 1, DOOR_CODE_OPENING, 0, 0, 1, 0, 99);
		plan_row(0, 5818, 32'h0000_000F, 1, DOOR_CODE_OPENING, 0, 200, 0, 1, 99);
		plan_row(0, 0, 32'hFFFF_FFEF, 1, DOOR_CODE_OPEN, 0, 0, 0, 1, 0);
		plan_row(0, 5819, 5, 1, DOOR_CODE_OPEN, 0, 0, 0, 1, 99);
		plan_row(0, 5820, 6, 0, DOOR_CODE_CLOSED, 0, 0, 0, 0, 0);
		plan_row(0, 20'(ECHO_MAX), 2005, 0, DOOR_CODE_CLOSED, 0, 0, 0, 0, 0);
		plan_row(0, 20'(ECHO_MAX), 2006, 0, DOOR_CODE_CLOSED, 0, 0, 0, 0, 0);
		plan_row(1, 12345, 7, 0, DOOR_CODE_CLOSED, 0, 0, 0, 0, 0);
		plan_row(0, 777, 8, 0, DOOR_CODE_CLOSED, 0, 0, 0, 0, 0);
		plan_row(1, 777, 9, 0, DOOR_CODE_CLOSED, 0, 0, 0, 0, 0);

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (plan_q[i])
			push_tick(plan_q[i].stim, plan_q[i].typed, plan_q[i].want);
		drain();

		run_phase(400, 16'd100, 16'd40, 16'hAB37);
		run_phase(100, 16'd0, 16'd0, 16'h0000);
		run_phase(350, 16'hFFFF, 16'hFFFF, 16'h00FF);
		run_phase(350, 16'd200, 16'd0, 16'h0001);
		run_phase(400, 16'($urandom_range(2000, 0)), 16'($urandom_range(3000, 0)),
			16'($urandom()));
		run_phase(300, 16'd17183, 16'd10, 16'h0080);

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
